FILE: hdl/gbn_pkg.sv
// Shared types, constants and helpers for the go-back-n sender window core.
`default_nettype none

package gbn_pkg;

  // Width of the sequence, base and count fields on the ports.
  localparam int SEQ_W = 16;
  localparam int WSIZE_W = 7;
  localparam int CMD_W = 2;

  // Defaults handed to the top-level parameters.
  localparam int MAX_WINDOW_DEF = 64;
  localparam int SEQ_BITS_DEF = 16;

  // Event queue depth between front and back (power of two).
  localparam int Q_DEPTH = 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WND_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_XFER_LEN = 1'b1;

  localparam logic [WSIZE_W-1:0] WND_LEN_RST = 7'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  // Input word.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SEQ_W-1:0] ack_num;
  } in_t;

  // Output word.
  typedef struct packed {
    logic             send_valid;
    logic [SEQ_W-1:0] send_seq;
    logic [SEQ_W-1:0] window_base;
    logic [SEQ_W-1:0] retransmit_count;
    logic             transfer_done;
    logic             last_result;
  } out_t;

  // Classified event as it travels from front to back.
  typedef struct packed {
    logic             start;
    logic             ack;
    logic             timeout;
    logic [SEQ_W-1:0] ack_num;
  } ev_t;

  // Mask that keeps the low sequence bits of a field.
  function automatic logic [SEQ_W-1:0] seq_mask(input int bits);
    logic [SEQ_W-1:0] m;
    begin
      m = '1;
      if (bits < SEQ_W) begin
        m = SEQ_W'((32'd1 << bits) - 32'd1);
      end
      return m;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gbn_front.sv
// Front end: accept event words, classify them and queue them for the back end.
`default_nettype none

module gbn_front #(
  parameter int SEQ_BITS = gbn_pkg::SEQ_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          evt_valid,
  output logic          evt_stall,
  input  gbn_pkg::in_t  evt,
  output logic          head_valid,
  output gbn_pkg::ev_t  head,
  input  logic          head_pop
);
  import gbn_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [SEQ_W-1:0] ACK_MASK = seq_mask(SEQ_BITS);

  ev_t              q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  ev_t              cls;
  logic             push;
  logic             pop;

  // Decode the command into event flags, at most one set (none for a nop).
  always_comb begin
    cls = '0;
    cls.ack_num = evt.ack_num & ACK_MASK;
    case (cmd_t'(evt.cmd))
      CMD_START:   cls.start = 1'b1;
      CMD_ACK:     cls.ack = 1'b1;
      CMD_TIMEOUT: cls.timeout = 1'b1;
      default:     cls.start = 1'b0;
    endcase
  end

  assign evt_stall  = (count == CNT_W'(Q_DEPTH));
  assign push       = evt_valid && !evt_stall;
  assign head_valid = (count != '0);
  assign pop        = head_pop && head_valid;
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(Q_DEPTH))
    else $error("event queue over capacity");

endmodule

`default_nettype wire

FILE: hdl/gbn_back.sv
// Back end: apply queued events to the window state and emit one word per send, or one status-only word.
`default_nettype none

module gbn_back #(
  parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF,
  parameter int SEQ_BITS   = gbn_pkg::SEQ_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [gbn_pkg::WSIZE_W-1:0]   wnd_len,
  input  logic [gbn_pkg::SEQ_W-1:0]     xfer_len,
  input  logic                          head_valid,
  input  gbn_pkg::ev_t                  head,
  output logic                          head_pop,
  output logic                          res_valid,
  input  logic                          res_stall,
  output gbn_pkg::out_t                 res
);
  import gbn_pkg::*;

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam logic [SEQ_W-1:0] TOT_MASK = seq_mask(SEQ_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIMIT,
    S_SEND
  } state_t;

  state_t           state;
  logic [SEQ_W-1:0] base;
  logic [SEQ_W-1:0] nxt;
  logic [SEQ_W-1:0] tcount;
  logic [SEQ_W-1:0] limit;
  logic             done;
  logic             has_send;

  logic [SEQ_W-1:0] total;
  logic [WIN_W-1:0] win;
  logic             done_now;
  logic [SEQ_W:0]   ack_inc;
  logic [SEQ_W-1:0] new_base;
  logic [SEQ_W:0]   lim_sum;
  logic [SEQ_W-1:0] limit_next;
  logic [SEQ_W:0]   nxt_inc;
  logic             is_last;
  logic             res_free;
  logic             word_load;

  assign total     = xfer_len & TOT_MASK;
  assign done_now  = (base >= total);
  assign head_pop  = (state == S_IDLE) && head_valid;
  assign res_free  = !res_valid || !res_stall;
  assign word_load = (state == S_SEND) && res_free;

  // Clamp the window into 1..MAX_WINDOW.
  always_comb begin
    if (wnd_len == '0) begin
      win = WIN_W'(1);
    end else if (wnd_len > WSIZE_W'(MAX_WINDOW)) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(wnd_len);
    end
  end

  // Cumulative ack slides base to ack+1, saturated at the total.
  always_comb begin
    ack_inc = {1'b0, head.ack_num} + (SEQ_W+1)'(1);
    if (ack_inc > {1'b0, total}) begin
      new_base = total;
    end else begin
      new_base = ack_inc[SEQ_W-1:0];
    end
  end

  always_comb begin
    lim_sum = {1'b0, base} + (SEQ_W+1)'(win);
    if (lim_sum > {1'b0, total}) begin
      limit_next = total;
    end else begin
      limit_next = lim_sum[SEQ_W-1:0];
    end
  end

  assign nxt_inc = {1'b0, nxt} + (SEQ_W+1)'(1);
  assign is_last = (nxt_inc == {1'b0, limit});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      base      <= '0;
      nxt       <= '0;
      tcount    <= '0;
      res_valid <= 1'b0;
    end else begin
      // Raise valid on a load, drop it once the word is taken.
      if (word_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            if (head.start) begin
              base   <= '0;
              nxt    <= '0;
              tcount <= '0;
            end else if (head.ack) begin
              if (!done_now && head.ack_num >= base) begin
                base <= new_base;
                if (nxt < new_base) begin
                  nxt <= new_base;
                end
              end
            end else if (head.timeout) begin
              if (!done_now) begin
                nxt <= base;
                if (tcount != '1) begin
                  tcount <= tcount + SEQ_W'(1);
                end
              end
            end
            state <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          limit    <= limit_next;
          done     <= done_now;
          has_send <= (nxt < limit_next);
          state    <= S_SEND;
        end
        S_SEND: begin
          if (res_free) begin
            res.window_base      <= base;
            res.retransmit_count <= tcount;
            res.transfer_done    <= done;
            if (!has_send) begin
              res.send_valid  <= 1'b0;
              res.send_seq    <= '0;
              res.last_result <= 1'b1;
              state           <= S_IDLE;
            end else begin
              res.send_valid  <= 1'b1;
              res.send_seq    <= nxt;
              res.last_result <= is_last;
              nxt             <= nxt_inc[SEQ_W-1:0];
              if (is_last) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_next_above_base: assert property (@(posedge clk) disable iff (rst)
    nxt >= base)
    else $error("next sequence fell below window base");

  a_send_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND && has_send) |-> nxt < limit)
    else $error("sending past the window limit");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.send_valid) |-> res.last_result)
    else $error("status-only word not marked last");

  a_send_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND && res_free && has_send) |=> (res_valid && res.send_valid))
    else $error("send step did not load an output word");

endmodule

`default_nettype wire

FILE: hdl/go_back_n_sender_window_core.sv
// Top level of the go-back-n sender window core: configuration and front/back wiring.
//
// Go-back-n sender window control. Each event word (start, cumulative ack or
// timeout) updates the window base, the next sequence number and a saturating
// retransmission count, and the core then emits one output word per sequence
// number now released for transmission, limited by the window size and the
// transfer total; an event that releases nothing yields one status-only word
// (send_valid low). The final word of each event carries last_result. Events
// enter a two-entry queue, so up to two may be accepted while the back end is
// busy. The back end applies an event in S_IDLE, computes the window limit in
// S_LIMIT, then in S_SEND loads one output word per cycle into the single output
// register while the output is not stalled; an event yields N words, N from 1 to
// the window size (at most MAX_WINDOW). Configuration is a plain write port
// (index 0 window length, index 1 transfer length in packets) and must only be
// written while the core is idle. No clearing pass follows reset.
`default_nettype none

module go_back_n_sender_window_core #(
  parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF,
  parameter int SEQ_BITS   = gbn_pkg::SEQ_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            evt_valid,
  output logic                            evt_stall,
  input  gbn_pkg::in_t                    evt,
  output logic                            res_valid,
  input  logic                            res_stall,
  output gbn_pkg::out_t                   res,
  input  logic                            cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbn_pkg::SEQ_W-1:0]       cfg_data
);
  import gbn_pkg::*;

  logic [WSIZE_W-1:0] wnd_len;
  logic [SEQ_W-1:0]   xfer_len;
  logic               head_valid;
  ev_t                head;
  logic               head_pop;

  // Configuration registers; hold between writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      wnd_len  <= WND_LEN_RST;
      xfer_len <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WND_LEN:  wnd_len <= cfg_data[WSIZE_W-1:0];
        REG_XFER_LEN: xfer_len <= cfg_data;
        default:      wnd_len <= wnd_len;
      endcase
    end
  end

  // Accept and classify events, queue them.
  gbn_front #(
    .SEQ_BITS (SEQ_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .evt        (evt),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  // Apply events to the window and drive the output words.
  gbn_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SEQ_BITS   (SEQ_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .wnd_len    (wnd_len),
    .xfer_len   (xfer_len),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

endmodule

`default_nettype wire
